### design/linear_adsr_voice_envelope_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear ADSR voice envelope
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADSR_VOICE_ENVELOPE_TOP_DEFINES_SVH
`define LINEAR_ADSR_VOICE_ENVELOPE_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define LAVENV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("envelope check failed");

// Next-cycle implication, ignored while reset is applied.
`define LAVENV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("envelope check failed");

// Next-cycle implication that is checked through reset as well.
`define LAVENV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("envelope check failed");

`endif

### design/lavenv_pkg.sv
// ----------------------------------------------------------------------------
// Linear ADSR voice envelope package
// Widths, codes, reset values and request/result types shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lavenv_pkg;

    localparam int unsigned LEVEL_W  = 25;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned VEL_W    = 7;
    localparam int unsigned STAGE_W  = 3;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Full scale is 1.0; the release ends at or below 0.0001 of full scale.
    localparam logic [LEVEL_W-1:0] FULL_SCALE    = 25'd16777216;
    localparam logic [LEVEL_W-1:0] END_THRESHOLD = 25'd1677;

    localparam logic [LEVEL_W-1:0] ATTACK_STEP_RST   = 25'd998;
    localparam logic [LEVEL_W-1:0] DECAY_STEP_RST    = 25'd196;
    localparam logic [LEVEL_W-1:0] SUSTAIN_LEVEL_RST = 25'd12079595;
    localparam logic [LEVEL_W-1:0] RELEASE_RATE_RST  = 25'd291;

    typedef enum logic [STAGE_W-1:0] {
        STAGE_OFF     = 3'd0,
        STAGE_ATTACK  = 3'd1,
        STAGE_DECAY   = 3'd2,
        STAGE_SUSTAIN = 3'd3,
        STAGE_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_STEP   = 2'd0,
        CFG_DECAY_STEP    = 2'd1,
        CFG_SUSTAIN_LEVEL = 2'd2,
        CFG_RELEASE_RATE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NOTE_W-1:0]   note_number;
        logic [VEL_W-1:0]    note_velocity;
    } t_req;

    typedef struct packed {
        logic [LEVEL_W-1:0] envelope_level;
        logic [VEL_W-1:0]   held_velocity;
        logic [STAGE_W-1:0] env_stage;
        logic               voice_active;
    } t_res;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [LEVEL_W-1:0] release_rate;
    } t_cfg;

endpackage

`default_nettype wire

### design/lavenv_req_if.sv
// ----------------------------------------------------------------------------
// Envelope request channel
// Valid/ready channel that carries tick, note-on and note-off requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lavenv_req_if;

    logic              valid;
    logic              ready;
    lavenv_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);

endinterface

`default_nettype wire

### design/lavenv_res_if.sv
// ----------------------------------------------------------------------------
// Envelope result channel
// Valid/ready channel that carries the envelope state after each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lavenv_res_if;

    logic              valid;
    logic              ready;
    lavenv_pkg::t_res  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);

endinterface

`default_nettype wire

### design/lavenv_cfg.sv
// ----------------------------------------------------------------------------
// Envelope configuration registers
// Holds the attack, decay, sustain and release settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lavenv_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lavenv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lavenv_pkg::LEVEL_W-1:0]      i_cfg_data,
    output lavenv_pkg::t_cfg                         o_cfg
);

    lavenv_pkg::t_cfg r_cfg;
    lavenv_pkg::t_cfg n_cfg;

    // The sustain level is stored already limited to full scale.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (lavenv_pkg::t_cfg_idx'(i_cfg_idx))
                lavenv_pkg::CFG_ATTACK_STEP:   n_cfg.attack_step = i_cfg_data;
                lavenv_pkg::CFG_DECAY_STEP:    n_cfg.decay_step  = i_cfg_data;
                lavenv_pkg::CFG_SUSTAIN_LEVEL: begin
                    n_cfg.sustain_level = (i_cfg_data > lavenv_pkg::FULL_SCALE) ?
                                          lavenv_pkg::FULL_SCALE : i_cfg_data;
                end
                lavenv_pkg::CFG_RELEASE_RATE:  n_cfg.release_rate = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step   <= lavenv_pkg::ATTACK_STEP_RST;
            r_cfg.decay_step    <= lavenv_pkg::DECAY_STEP_RST;
            r_cfg.sustain_level <= lavenv_pkg::SUSTAIN_LEVEL_RST;
            r_cfg.release_rate  <= lavenv_pkg::RELEASE_RATE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/lavenv_core.sv
// ----------------------------------------------------------------------------
// Envelope state and update logic
// Holds the voice state and computes its next value for each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lavenv_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire lavenv_pkg::t_req i_req,
    input  wire lavenv_pkg::t_cfg i_cfg,
    output lavenv_pkg::t_res    o_next
);

    localparam int unsigned LW = lavenv_pkg::LEVEL_W;

    logic [LW-1:0]                    r_level;
    logic [LW-1:0]                    n_level;
    lavenv_pkg::t_stage               r_stage;
    lavenv_pkg::t_stage               n_stage;
    logic [lavenv_pkg::NOTE_W-1:0]    r_note;
    logic [lavenv_pkg::NOTE_W-1:0]    n_note;
    logic [lavenv_pkg::VEL_W-1:0]     r_velocity;
    logic [lavenv_pkg::VEL_W-1:0]     n_velocity;
    logic [LW-1:0]                    r_release_step;
    logic [LW-1:0]                    n_release_step;

    logic [LW:0]                      attack_sum;
    logic [LW-1:0]                    decay_diff;
    logic [LW-1:0]                    release_diff;
    logic [2*LW-1:0]                  release_prod;

    assign attack_sum   = {1'b0, r_level} + {1'b0, i_cfg.attack_step};
    assign decay_diff   = (r_level > i_cfg.decay_step) ? (r_level - i_cfg.decay_step) : '0;
    assign release_diff = (r_level > r_release_step) ? (r_level - r_release_step) : '0;
    assign release_prod = {{LW{1'b0}}, r_level} * {{LW{1'b0}}, i_cfg.release_rate};

    always_comb begin
        n_level        = r_level;
        n_stage        = r_stage;
        n_note         = r_note;
        n_velocity     = r_velocity;
        n_release_step = r_release_step;
        case (lavenv_pkg::t_action'(i_req.action))
            lavenv_pkg::ACT_TICK: begin
                unique case (r_stage)
                    lavenv_pkg::STAGE_ATTACK: begin
                        if (attack_sum >= {1'b0, lavenv_pkg::FULL_SCALE}) begin
                            n_level = lavenv_pkg::FULL_SCALE;
                            n_stage = lavenv_pkg::STAGE_DECAY;
                        end else begin
                            n_level = attack_sum[LW-1:0];
                        end
                    end
                    lavenv_pkg::STAGE_DECAY: begin
                        if (decay_diff <= i_cfg.sustain_level) begin
                            n_level = i_cfg.sustain_level;
                            n_stage = lavenv_pkg::STAGE_SUSTAIN;
                        end else begin
                            n_level = decay_diff;
                        end
                    end
                    lavenv_pkg::STAGE_SUSTAIN: begin
                        n_level = i_cfg.sustain_level;
                    end
                    lavenv_pkg::STAGE_RELEASE: begin
                        if (release_diff <= lavenv_pkg::END_THRESHOLD) begin
                            n_level = '0;
                            n_stage = lavenv_pkg::STAGE_OFF;
                        end else begin
                            n_level = release_diff;
                        end
                    end
                    default: n_level = r_level;
                endcase
            end
            lavenv_pkg::ACT_NOTE_ON: begin
                n_note         = i_req.note_number;
                n_velocity     = i_req.note_velocity;
                n_level        = '0;
                n_release_step = '0;
                n_stage        = lavenv_pkg::STAGE_ATTACK;
            end
            lavenv_pkg::ACT_NOTE_OFF: begin
                // Only the held note releases the voice.
                if (r_stage != lavenv_pkg::STAGE_OFF && i_req.note_number == r_note) begin
                    n_release_step = release_prod[lavenv_pkg::FRAC_W +: LW];
                    n_stage        = lavenv_pkg::STAGE_RELEASE;
                end
            end
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= '0;
            r_stage        <= lavenv_pkg::STAGE_OFF;
            r_note         <= '0;
            r_velocity     <= '0;
            r_release_step <= '0;
        end else if (i_accept) begin
            r_level        <= n_level;
            r_stage        <= n_stage;
            r_note         <= n_note;
            r_velocity     <= n_velocity;
            r_release_step <= n_release_step;
        end
    end

    assign o_next.envelope_level = n_level;
    assign o_next.held_velocity  = n_velocity;
    assign o_next.env_stage      = n_stage;
    assign o_next.voice_active   = (n_stage != lavenv_pkg::STAGE_OFF);

endmodule

`default_nettype wire

### design/linear_adsr_voice_envelope_top.sv
// ----------------------------------------------------------------------------
// Linear ADSR voice envelope
// Output: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle, limited only by result back-pressure.
// Reset: synchronous and active low; the voice goes off at level zero and
// the settings return to their default values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The block models one synthesiser voice. Each request is a sample tick, a
// note-on or a note-off, and each request gives exactly one result: the
// envelope state once the request has been applied.
//
// Structure: the configuration registers feed the core, whose state
// registers and next-state logic work out the new state in the same cycle
// as the request is accepted. That new state is captured in the output
// register, which separates the two channels, so a new request is taken
// whenever the output register is empty or its content is being taken in
// that same cycle. The longest path is the note-off release-step product
// of the level and the release rate, which goes straight into the state
// register.
//
// Settings should only be changed while no result is outstanding.

module linear_adsr_voice_envelope_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    lavenv_req_if.sink                               i_req,
    lavenv_res_if.source                             o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [lavenv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lavenv_pkg::LEVEL_W-1:0]      i_cfg_data
);

    lavenv_pkg::t_cfg cfg;
    lavenv_pkg::t_res next_res;
    logic             req_accept;

    logic             r_out_valid;
    lavenv_pkg::t_res r_out;

    // A request is taken when the output register is free or being emptied.
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_accept  = i_req.valid && i_req.ready;

    lavenv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lavenv_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (req_accept),
        .i_req    (i_req.payload),
        .i_cfg    (cfg),
        .o_next   (next_res)
    );

    // Output register: valid is control state, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_out <= next_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

`default_nettype wire

### design/lavenv_chk.sv
// ----------------------------------------------------------------------------
// Linear ADSR voice envelope port checker
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_adsr_voice_envelope_top_defines.svh"

module lavenv_chk (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire logic             i_req_ready,
    input  wire lavenv_pkg::t_req i_req_payload,
    input  wire logic             i_res_valid,
    input  wire logic             i_res_ready,
    input  wire lavenv_pkg::t_res i_res_payload
);

    logic req_accept;
    logic note_on_accept;
    logic res_attack_start;
    logic res_sane;

    assign req_accept     = i_req_valid && i_req_ready;
    assign note_on_accept = req_accept &&
                            (i_req_payload.action == lavenv_pkg::ACT_NOTE_ON);

    assign res_attack_start = i_res_valid &&
                              (i_res_payload.env_stage == lavenv_pkg::STAGE_ATTACK) &&
                              (i_res_payload.envelope_level == '0);

    assign res_sane = (i_res_payload.voice_active ==
                       (i_res_payload.env_stage != lavenv_pkg::STAGE_OFF)) &&
                      (i_res_payload.envelope_level <= lavenv_pkg::FULL_SCALE);

    // No result is offered straight after reset.
    `LAVENV_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_res_valid)

    // A stalled result is held unchanged.
    `LAVENV_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_payload))

    // A note-on request restarts the attack from silence with its velocity.
    `LAVENV_ASSERT_NEXT(a_note_on_starts, i_clk, i_rst_n, note_on_accept,
        res_attack_start && (i_res_payload.held_velocity == $past(i_req_payload.note_velocity)))

    // Active flag follows the stage, and the level never passes full scale.
    `LAVENV_ASSERT_NOW(a_result_sane, i_clk, i_rst_n, i_res_valid, res_sane)

endmodule

bind linear_adsr_voice_envelope_top lavenv_chk u_lavenv_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_payload (i_req.payload),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload)
);

`default_nettype wire
